// ----- rtl/core/htfd_pkg.sv -----
// Package of constants, types and the CRC-8 function for the frame decoder.
package htfd_pkg;

  // CRC-8 over the status and data bytes: polynomial 0x31, MSB first.
  localparam logic [7:0] CRC_POLY     = 8'h31;
  localparam logic [7:0] CRC_INIT     = 8'hFF;
  localparam logic [7:0] CRC_MSB      = 8'h80;

  // Frame layout: status byte at position 0, CRC byte at position 6.
  localparam logic [2:0] POS_STATUS   = 3'd0;
  localparam logic [2:0] CRC_BYTE_POS = 3'd6;

  // Field widths of the frame and of the results.
  localparam int RAW_W   = 20;
  localparam int DATA_W  = 40;
  localparam int HUM_W   = 10;
  localparam int TEMP_W  = 12;

  // Scaling constants: tenths of %RH and tenths of degrees C.
  localparam logic [9:0]  HUM_SCALE   = 10'd1000;
  localparam logic [10:0] TEMP_SCALE  = 11'd2000;
  localparam logic [11:0] TEMP_OFFSET = 12'd500;

  typedef logic [RAW_W-1:0]  raw_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [HUM_W-1:0]  hum_t;
  typedef logic [TEMP_W-1:0] temp_t;

  // Scaled readings passed from the scaling unit to the top level.
  typedef struct packed {
    hum_t  humidity;
    temp_t temperature;
  } reading_t;

  // One byte of the CRC-8 register update.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((v & CRC_MSB) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/htfd_scale.sv -----
// Scaling of the raw humidity and temperature fields to tenths.
module htfd_scale import htfd_pkg::*; (
  input  data_t    data_i,
  output reading_t reading_o
);

  raw_t        hum_raw;
  raw_t        temp_raw;
  logic [29:0] hum_prod;
  logic [30:0] temp_prod;
  logic [10:0] temp_scaled;

  // Humidity sits in the upper 20 bits, temperature in the lower 20 bits.
  assign hum_raw  = data_i[DATA_W-1:RAW_W];
  assign temp_raw = data_i[RAW_W-1:0];

  // Multiply by the constant and drop the 20 fraction bits.
  assign hum_prod  = 30'(hum_raw) * 30'(HUM_SCALE);
  assign temp_prod = 31'(temp_raw) * 31'(TEMP_SCALE);

  assign temp_scaled = temp_prod[30:20];

  assign reading_o.humidity    = hum_prod[29:20];
  assign reading_o.temperature = 12'(temp_scaled) - TEMP_OFFSET;

endmodule

// ----- rtl/core/humidity_temp_frame_decoder_core.sv -----
// Top level of the humidity/temperature sensor frame decoder.
// The block takes the seven-byte sensor frame one byte per transaction (status byte,
// five data bytes, CRC byte) and returns one result transaction per complete frame,
// with the humidity in tenths of %RH, the temperature in tenths of degrees C, the
// status byte and a CRC error flag; on a CRC error the last good readings are
// repeated. A byte with in_tuser high always starts a new frame and drops any partial
// one. Each byte passes an input register, then the CRC update, frame state and
// constant scaling feed the output register, so a byte is accepted every cycle while
// the output side takes its results.
module humidity_temp_frame_decoder_core import htfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] humidity_tenths, [21:10] temperature_tenths,
                                  // [29:22] status_byte, [31:30] zero
  output logic        out_tuser   // [0] crc_error
);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // Frame state.
  logic [2:0] byte_idx_r,  byte_idx_nxt;
  logic [7:0] crc_r,       crc_nxt;
  data_t      data_r,      data_nxt;
  logic [7:0] status_r,    status_nxt;
  hum_t       last_hum_r,  last_hum_nxt;
  temp_t      last_temp_r, last_temp_nxt;

  // Output register.
  logic       out_valid_r;
  hum_t       out_hum_r;
  temp_t      out_temp_r;
  logic [7:0] out_status_r;
  logic       out_err_r;

  logic       out_free;
  logic       s1_fire;
  logic [2:0] pos;
  logic       crc_err;
  logic       frame_done;
  reading_t   reading;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  htfd_scale u_scale (
    .data_i    (data_r),
    .reading_o (reading)
  );

  // Position of this byte: a start flag or an out-of-range index restarts the frame.
  always_comb begin
    if (s1_start_r || byte_idx_r > CRC_BYTE_POS) begin
      pos = POS_STATUS;
    end else begin
      pos = byte_idx_r;
    end
  end

  assign crc_err    = (crc_r != s1_byte_r);
  assign frame_done = (pos == CRC_BYTE_POS);

  // Frame state update for the byte in the input register.
  always_comb begin
    byte_idx_nxt  = byte_idx_r;
    crc_nxt       = crc_r;
    data_nxt      = data_r;
    status_nxt    = status_r;
    last_hum_nxt  = last_hum_r;
    last_temp_nxt = last_temp_r;
    if (s1_fire) begin
      if (pos == POS_STATUS) begin
        status_nxt   = s1_byte_r;
        crc_nxt      = crc8_update(CRC_INIT, s1_byte_r);
        data_nxt     = '0;
        byte_idx_nxt = 3'd1;
      end else if (!frame_done) begin
        crc_nxt      = crc8_update(crc_r, s1_byte_r);
        data_nxt     = {data_r[DATA_W-9:0], s1_byte_r};
        byte_idx_nxt = pos + 3'd1;
      end else begin
        if (!crc_err) begin
          last_hum_nxt  = reading.humidity;
          last_temp_nxt = reading.temperature;
        end
        byte_idx_nxt = POS_STATUS;
        crc_nxt      = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= POS_STATUS;
      crc_r       <= CRC_INIT;
      data_r      <= '0;
      status_r    <= '0;
      last_hum_r  <= '0;
      last_temp_r <= '0;
    end else begin
      byte_idx_r  <= byte_idx_nxt;
      crc_r       <= crc_nxt;
      data_r      <= data_nxt;
      status_r    <= status_nxt;
      last_hum_r  <= last_hum_nxt;
      last_temp_r <= last_temp_nxt;
    end
  end

  // Output register: a result transaction for each completed frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && frame_done) begin
      out_hum_r    <= last_hum_nxt;
      out_temp_r   <= last_temp_nxt;
      out_status_r <= status_r;
      out_err_r    <= crc_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_status_r, out_temp_r, out_hum_r};
  assign out_tuser  = out_err_r;

endmodule

// ----- rtl/core/htfd_checker.sv -----
// Port checker for the frame decoder, bound to the top level.
module htfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Humidity never exceeds 99.9 %RH.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:0] <= 10'd999)
    else $error("humidity out of range");

  // Temperature stays between -50.0 and 149.9 degrees C.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[21:10]) >= -12'sd500) &&
                   ($signed(out_tdata[21:10]) <= 12'sd1499))
    else $error("temperature out of range");

  // No result is offered straight after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // When the receiver takes results, the input side is never held off.
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while the output side was ready");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the humidity/temperature sensor frame decoder.
`timescale 1ns / 100ps

module tb_top;
  import htfd_pkg::*;

  localparam int  RANDOM_BYTES = 330;
  localparam int  LONG_HOLD    = 150;
  localparam int  DRAIN_CYCLES = 6;
  localparam int  CYCLE_LIMIT  = 200000;

  // Receiver behaviour during one stretch of cycles.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_t;

  // One decoded reading as the block should return it.
  typedef struct {
    hum_t       humidity;
    temp_t      temperature;
    logic       crc_error;
    logic [7:0] status;
  } frame_reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  // Decoder state as the testbench tracks it.
  logic [2:0]  frame_pos = POS_STATUS;
  logic [7:0]  crc_run = CRC_INIT;
  data_t       data_bytes = '0;
  logic [7:0]  status_latch = 8'h00;
  hum_t        held_hum = '0;
  temp_t       held_temp = '0;

  frame_reading_t readings_due[$];

  int       mismatches = 0;
  int       bytes_sent = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       pacing_on = 1'b1;
  int       hold_cycles = 0;
  int       stretch_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;

  humidity_temp_frame_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // CRC-8, polynomial 0x31, most significant bit first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    repeat (8) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %0s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Advance the decoder state by one accepted byte; a completed frame queues a reading.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [2:0]     pos;
    logic [39:0]    hum_prod;
    logic [39:0]    temp_prod;
    frame_reading_t r;
    pos = start ? POS_STATUS : frame_pos;
    if (pos > CRC_BYTE_POS) begin
      pos = POS_STATUS;
    end
    if (pos == POS_STATUS) begin
      status_latch = b;
      crc_run      = crc8_step(CRC_INIT, b);
      data_bytes   = '0;
      frame_pos    = 3'd1;
    end else if (pos < CRC_BYTE_POS) begin
      crc_run    = crc8_step(crc_run, b);
      data_bytes = {data_bytes[31:0], b};
      frame_pos  = pos + 3'd1;
    end else begin
      r.crc_error = (crc_run != b);
      // Only a frame with a matching CRC updates the held readings.
      if (!r.crc_error) begin
        hum_prod  = 40'(data_bytes[39:20]) * 40'(HUM_SCALE);
        temp_prod = 40'(data_bytes[19:0]) * 40'(TEMP_SCALE);
        held_hum  = hum_prod[29:20];
        held_temp = temp_prod[31:20] - TEMP_OFFSET;
      end
      r.humidity    = held_hum;
      r.temperature = held_temp;
      r.status      = status_latch;
      readings_due.push_back(r);
      frame_pos = POS_STATUS;
      crc_run   = CRC_INIT;
    end
  endtask

  // Compare one result transaction with the oldest reading due.
  task automatic check_reading();
    frame_reading_t want;
    if (readings_due.size() == 0) begin
      report_mismatch("result with nothing expected", out_tdata, 32'h0);
    end else begin
      want = readings_due.pop_front();
      if (out_tdata[9:0] !== want.humidity)
        report_mismatch("humidity", 32'(out_tdata[9:0]), 32'(want.humidity));
      if (out_tdata[21:10] !== want.temperature)
        report_mismatch("temperature", 32'(out_tdata[21:10]), 32'(want.temperature));
      if (out_tdata[29:22] !== want.status)
        report_mismatch("status byte", 32'(out_tdata[29:22]), 32'(want.status));
      if (out_tdata[31:30] !== 2'b00)
        report_mismatch("padding bits", 32'(out_tdata[31:30]), 32'h0);
      if (out_tuser !== want.crc_error)
        report_mismatch("crc error flag", 32'(out_tuser), 32'(want.crc_error));
    end
  endtask

  // Both channels are sampled at the rising edge; inputs are predicted before outputs are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tuser);
      end
      if (out_tvalid && out_tready) begin
        check_reading();
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: a long hold-off on request, otherwise stretches of differing readiness.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(4, 60);
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
      end
      stretch_left--;
      case (rx_mode)
        RX_ALWAYS: begin
          out_tready <= 1'b1;
        end
        RX_RANDOM: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Sender pacing: bursts of random length with random gaps between them.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Offer one byte and wait until its transaction completes.
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (pacing_on) begin
      pace();
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Status byte, five data bytes from the top down, then the CRC byte.
  task automatic send_frame(input logic [7:0] status, input logic start,
                            input data_t data, input logic corrupt);
    logic [7:0] crc;
    crc = crc8_step(CRC_INIT, status);
    send_byte(status, start);
    for (int i = 4; i >= 0; i--) begin
      crc = crc8_step(crc, data[i*8 +: 8]);
      send_byte(data[i*8 +: 8], 1'b0);
    end
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    send_byte(crc, 1'b0);
  endtask

  // Stop offering and wait until every reading due has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic data_t random_data();
    data_t d;
    d = {8'($urandom), $urandom};
    // Now and then push a field to one of its limits.
    case ($urandom_range(0, 7))
      0: d[39:20] = '0;
      1: d[39:20] = '1;
      2: d[19:0]  = '0;
      3: d[19:0]  = '1;
      default: ;
    endcase
    return d;
  endfunction

  // A CRC error straight after reset repeats zero readings; the first byte needs no start flag.
  task automatic test_error_after_reset();
    send_frame(8'h5A, 1'b0, 40'h123456789A, 1'b1);
  endtask

  // Smallest and largest raw readings, the second frame following without a start flag.
  task automatic test_extremes();
    send_frame(8'h00, 1'b1, '0, 1'b0);
    send_frame(8'hFF, 1'b0, '1, 1'b0);
  endtask

  // A start flag mid-frame drops the partial frame; a bad CRC then repeats the held values.
  task automatic test_restart();
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_frame(8'h81, 1'b1, random_data(), 1'b1);
  endtask

  // Mostly well-formed frames, with bad CRCs, truncated frames and stray bytes mixed in.
  task automatic test_random_traffic();
    int target;
    int pick;
    int len;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(8'($urandom), ($urandom_range(0, 3) != 0), random_data(), 1'b0);
      end else if (pick < 80) begin
        send_frame(8'($urandom), ($urandom_range(0, 3) != 0), random_data(), 1'b1);
      end else if (pick < 90) begin
        len = $urandom_range(1, 6);
        send_byte(8'($urandom), 1'b1);
        repeat (len - 1) send_byte(8'($urandom), 1'b0);
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // The receiver holds off while frames keep coming, so the input side must stall.
  task automatic test_backpressure();
    hold_cycles = LONG_HOLD;
    pacing_on = 1'b0;
    repeat (3) send_frame(8'($urandom), 1'b1, random_data(), 1'b0);
    pacing_on = 1'b1;
    wait_drained();
  endtask

  // After a full pause the decoder picks up fresh frames.
  task automatic test_drain_pause();
    wait_drained();
    send_frame(8'($urandom), 1'b0, random_data(), 1'b0);
    send_frame(8'($urandom), 1'b1, random_data(), 1'b1);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_error_after_reset();
    test_extremes();
    test_restart();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
